// ===== hw/rtl/euv_band_intensity_scaler_defines.svh =====
// Assertion macros for the intensity scaler.
`ifndef EUV_BAND_INTENSITY_SCALER_DEFINES_SVH
`define EUV_BAND_INTENSITY_SCALER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define EBIS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ebis: implication check failed");

// Next-cycle implication, disabled in reset.
`define EBIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ebis: next-cycle check failed");

`endif

// ===== hw/rtl/ebis_pkg.sv =====
package ebis_pkg;

   localparam int PIXEL_BITS_DEF = 16;
   localparam int OUT_FRAC_DEF   = 8;

   localparam int GAIN_W    = 19;
   localparam int INV_W     = 20;
   localparam int GEFF_W    = 23;
   localparam int X_W       = 31;
   localparam int MANT_W    = 31;
   localparam int LOG_FRAC  = 24;
   localparam int IPART_W   = 4;
   localparam int LOG10_W   = 31;
   localparam int OUT_W     = 23;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 20;

   localparam logic [LOG10_W-1:0] LOG10_2_Q32 = 31'd1292913986;
   localparam logic [OUT_W-1:0]   OUT_MAX     = 23'h7FFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_SELECT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_EXPOSURE = 1'b1;

   typedef enum logic [3:0] {
      BAND_94   = 4'd0,
      BAND_131  = 4'd1,
      BAND_171  = 4'd2,
      BAND_193  = 4'd3,
      BAND_211  = 4'd4,
      BAND_304  = 4'd5,
      BAND_335  = 4'd6,
      BAND_1600 = 4'd7,
      BAND_1700 = 4'd8,
      BAND_4500 = 4'd9
   } band_type;

   typedef enum logic [1:0] {
      XF_ID   = 2'd0,
      XF_SQRT = 2'd1,
      XF_LOG  = 2'd2
   } xf_type;

   localparam band_type          BAND_RESET = BAND_171;
   localparam logic [INV_W-1:0]  INV_RESET  = 20'd65536;

   // log path word: Q1.30 mantissa, fraction bits so far, integer part
   typedef struct packed {
      logic [MANT_W-1:0]   mant;
      logic [LOG_FRAC-1:0] frac;
      logic [IPART_W-1:0]  ipart;
   } lg_type;

   function automatic logic band_known(input band_type b);
      logic ok;
      ok = 1'b0;
      unique case (b)
         BAND_94, BAND_131, BAND_171, BAND_193, BAND_211,
         BAND_304, BAND_335, BAND_1600, BAND_1700, BAND_4500: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Q.16 band gains
   function automatic logic [GAIN_W-1:0] band_gain(input band_type b);
      logic [GAIN_W-1:0] g;
      g = '0;
      unique case (b)
         BAND_94:   g = 19'd327551;
         BAND_131:  g = 19'd458546;
         BAND_171:  g = 19'd327551;
         BAND_193:  g = 19'd196575;
         BAND_211:  g = 19'd327550;
         BAND_304:  g = 19'd327641;
         BAND_335:  g = 19'd458578;
         BAND_1600: g = 19'd196550;
         BAND_1700: g = 19'd65553;
         BAND_4500: g = 19'd65553;
         default:   g = '0;
      endcase
      return g;
   endfunction

   function automatic logic [X_W-1:0] band_lo(input band_type b);
      logic [X_W-1:0] v;
      v = '0;
      unique case (b)
         BAND_94:  v = 31'd92740;
         BAND_131: v = 31'd307887;
         BAND_171: v = 31'd439839;
         BAND_193: v = 31'd3574691;
         BAND_211: v = 31'd1787345;
         BAND_304: v = 31'd270586;
         BAND_335: v = 31'd77231;
         default:  v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [X_W-1:0] band_hi(input band_type b);
      logic [X_W-1:0] v;
      v = '0;
      unique case (b)
         BAND_94:   v = 31'd3091321;
         BAND_131:  v = 31'd52780671;
         BAND_171:  v = 31'd263903356;
         BAND_193:  v = 31'd178734545;
         BAND_211:  v = 31'd774516364;
         BAND_304:  v = 31'd10823452;
         BAND_335:  v = 31'd22065993;
         BAND_1600: v = 31'd13107200;
         BAND_1700: v = 31'd163840000;
         BAND_4500: v = 31'd1703936000;
         default:   v = '0;
      endcase
      return v;
   endfunction

   function automatic xf_type band_xf(input band_type b);
      xf_type xf;
      xf = XF_ID;
      unique case (b)
         BAND_94, BAND_171:                                    xf = XF_SQRT;
         BAND_131, BAND_193, BAND_211, BAND_304, BAND_335:     xf = XF_LOG;
         default:                                              xf = XF_ID;
      endcase
      return xf;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] v);
      return (v > 64'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/euv_band_intensity_scaler.sv =====
// Channel  | Ports                                  | Direction
// ---------+----------------------------------------+----------
// request  | req_valid, req_ready, req_pixel_in     | in
// response | rsp_valid, rsp_ready, rsp_scaled_value | out
// csr      | csr_wr_en, csr_index, csr_wdata        | in
//
// One pixel word per cycle sustained while the skid register is empty. The
// pipe depth is set by the one-step-per-stage square-root / log-squaring
// chain.
// Reset is synchronous and clears the valid bits, output and skid words and
// the csr registers (band 171, unit exposure).
// A stalled response parks one word in a skid register; the pipe halts only
// once that is full, so nothing is dropped or repeated.
`include "euv_band_intensity_scaler_defines.svh"

module euv_band_intensity_scaler #(
   parameter int PIXEL_BITS    = ebis_pkg::PIXEL_BITS_DEF,
   parameter int OUT_FRAC_BITS = ebis_pkg::OUT_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [PIXEL_BITS-1:0]       req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ebis_pkg::OUT_W-1:0]         rsp_scaled_value,
   input  logic                               csr_wr_en,
   input  logic [ebis_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ebis_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import ebis_pkg::*;

   localparam int V_W      = 2*(16+OUT_FRAC_BITS);
   localparam int R_W      = V_W/2;
   localparam int NI       = (R_W > LOG_FRAC) ? R_W : LOG_FRAC;
   localparam int N_STG    = 5 + NI;          // pipe stages before the output word
   localparam int PROD_W   = PIXEL_BITS + GEFF_W + 1;
   localparam int MUL_W    = GAIN_W + INV_W + 1;
   localparam int SH_L     = (2*OUT_FRAC_BITS >= 16) ? 2*OUT_FRAC_BITS-16 : 0;
   localparam int SH_R     = (2*OUT_FRAC_BITS >= 16) ? 0 : 16-2*OUT_FRAC_BITS;
   localparam int L2_W     = IPART_W + LOG_FRAC;
   localparam int LGP_W    = L2_W + LOG10_W;
   localparam int LG_SH    = LOG_FRAC + 32 - OUT_FRAC_BITS;
   localparam int ID_SH    = 16 - OUT_FRAC_BITS;

   // ---------------- csr registers ----------------
   band_type           band_ff;
   logic [INV_W-1:0]   inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= BAND_RESET;
         inv_ff  <= INV_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BAND_SELECT:  band_ff <= band_type'(csr_wdata[3:0]);
            CSR_INV_EXPOSURE: inv_ff  <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // effective gain, refreshed every cycle; user moves csr only while idle (not enforced)
   logic [MUL_W-1:0]  gmul;
   logic [GEFF_W-1:0] geff_ff, geff_in;

   always_comb begin
      gmul = MUL_W'(band_gain(band_ff)) * MUL_W'(inv_ff) + MUL_W'(32768);
      if (band_ff == BAND_1700) begin
         geff_in = GEFF_W'(band_gain(band_ff));
      end else begin
         geff_in = gmul[GEFF_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      geff_ff <= geff_in;
   end

   // ---------------- pipe control ----------------
   logic             skid_vld_ff;
   logic             en;
   logic [N_STG-1:0] vld_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_STG-2:0], req_valid};
      end
   end

   // stage 0: pixel capture
   logic signed [PIXEL_BITS-1:0] pix_ff;
   // stage 1: gain product
   logic signed [PROD_W-1:0]     prod_ff;
   // stage 2: clamp
   logic [X_W-1:0]               x_ff;
   logic [X_W-1:0]               x_in, lo_v, hi_v;
   logic signed [PROD_W-1:0]     lo_s, hi_s;

   always_comb begin
      lo_v = band_lo(band_ff);
      hi_v = band_hi(band_ff);
      lo_s = $signed(PROD_W'(lo_v));
      hi_s = $signed(PROD_W'(hi_v));
      if (prod_ff < lo_s) begin
         x_in = lo_v;
      end else if (prod_ff > hi_s) begin
         x_in = hi_v;
      end else begin
         x_in = prod_ff[X_W-1:0];
      end
   end

   // stage 3: set up square root and log mantissa
   logic [V_W-1:0] rem_s  [NI+1];
   logic [V_W-1:0] root_s [NI+1];
   lg_type         lg_s   [NI+1];
   logic [X_W-1:0] x_s    [NI+1];

   logic [4:0]     msb;
   logic [V_W-1:0] xe;
   lg_type         lg_in;

   always_comb begin
      msb = '0;
      for (int i = 0; i < X_W; i++) begin
         if (x_ff[i]) msb = 5'(i);
      end
      xe = V_W'(x_ff);
      lg_in.frac = '0;
      if (x_ff[X_W-1:16] == '0) begin
         // below one: mantissa of exactly one gives zero
         lg_in.mant  = {1'b1, {(MANT_W-1){1'b0}}};
         lg_in.ipart = '0;
      end else begin
         lg_in.mant  = x_ff << (5'd30 - msb);
         lg_in.ipart = IPART_W'(msb - 5'd16);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff     <= req_pixel_in;
         prod_ff    <= PROD_W'(pix_ff) * $signed({1'b0, geff_ff});
         x_ff       <= x_in;
         rem_s[0]   <= (xe << SH_L) >> SH_R;
         root_s[0]  <= '0;
         lg_s[0]    <= lg_in;
         x_s[0]     <= x_ff;
      end
   end

   // stages 4 .. 3+NI: one root step each in the first R_W, one squaring each in the first LOG_FRAC
   for (genvar g = 0; g < NI; g++) begin : g_iter
      ebis_iter_stage #(
         .OUT_FRAC_BITS (OUT_FRAC_BITS),
         .STEP          (g)
      ) u_iter (
         .clock  (clock),
         .load   (en),
         .rem_i  (rem_s[g]),
         .root_i (root_s[g]),
         .lg_i   (lg_s[g]),
         .x_i    (x_s[g]),
         .rem_o  (rem_s[g+1]),
         .root_o (root_s[g+1]),
         .lg_o   (lg_s[g+1]),
         .x_o    (x_s[g+1])
      );
   end

   // last stage: log2 to log10 scaling
   logic [LGP_W-1:0] lgp_ff;
   logic [R_W-1:0]   root_ff;
   logic [X_W-1:0]   xl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lgp_ff  <= LGP_W'({lg_s[NI].ipart, lg_s[NI].frac}) * LGP_W'(LOG10_2_Q32);
         root_ff <= root_s[NI][R_W-1:0];
         xl_ff   <= x_s[NI];
      end
   end

   // transfer function select and saturation; unknown bands give zero
   logic [OUT_W-1:0] res;

   always_comb begin
      case (band_xf(band_ff))
         XF_SQRT: res = sat_out(64'(root_ff));
         XF_LOG:  res = sat_out(64'(lgp_ff >> LG_SH));
         default: res = sat_out(64'(xl_ff >> ID_SH));
      endcase
      if (!band_known(band_ff)) res = '0;
   end

   // ---------------- output word and skid ----------------
   logic             emit, pop;
   logic             rsp_vld_ff;
   logic [OUT_W-1:0] rsp_ff, skid_ff;

   assign emit = en && vld_ff[N_STG-1];
   assign pop  = rsp_vld_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
         rsp_ff      <= '0;
         skid_ff     <= '0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            rsp_ff      <= skid_ff;
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!rsp_vld_ff || pop) begin
         rsp_ff     <= res;
         rsp_vld_ff <= emit;
      end else if (emit) begin
         skid_ff     <= res;
         skid_vld_ff <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_scaled_value = rsp_ff;

   // ---------------- checks ----------------
   `EBIS_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_vld_ff)
   `EBIS_ASSERT_NEXT(a_stall_parks, clock, reset, emit && rsp_vld_ff && !rsp_ready, skid_vld_ff)
   `EBIS_ASSERT_NEXT(a_skid_holds, clock, reset, skid_vld_ff && !rsp_ready, skid_vld_ff)

endmodule

// ===== hw/rtl/ebis_iter_stage.sv =====
module ebis_iter_stage #(
   parameter int OUT_FRAC_BITS = ebis_pkg::OUT_FRAC_DEF,
   parameter int STEP          = 0
) (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic [2*(16+OUT_FRAC_BITS)-1:0]       rem_i,
   input  logic [2*(16+OUT_FRAC_BITS)-1:0]       root_i,
   input  ebis_pkg::lg_type                      lg_i,
   input  logic [ebis_pkg::X_W-1:0]              x_i,
   output logic [2*(16+OUT_FRAC_BITS)-1:0]       rem_o,
   output logic [2*(16+OUT_FRAC_BITS)-1:0]       root_o,
   output ebis_pkg::lg_type                      lg_o,
   output logic [ebis_pkg::X_W-1:0]              x_o
);
   import ebis_pkg::*;

   localparam int V_W      = 2*(16+OUT_FRAC_BITS);
   localparam int SQ_STEPS = V_W/2;
   localparam int SQ_POS   = (STEP < SQ_STEPS) ? V_W-2-2*STEP : 0;
   localparam logic [V_W-1:0] SQ_BIT = {{(V_W-1){1'b0}}, 1'b1} << SQ_POS;

   logic [V_W-1:0]      rem_ff, rem_in, root_ff, root_in, trial;
   lg_type              lg_ff, lg_in;
   logic [X_W-1:0]      x_ff;
   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0]     sq_top;

   // one restoring square-root step
   always_comb begin
      trial   = root_i + SQ_BIT;
      rem_in  = rem_i;
      root_in = root_i;
      if (STEP < SQ_STEPS) begin
         if (rem_i >= trial) begin
            rem_in  = rem_i - trial;
            root_in = (root_i >> 1) + SQ_BIT;
         end else begin
            root_in = root_i >> 1;
         end
      end
   end

   // one squaring of the log mantissa yields one fraction bit
   always_comb begin
      sq     = (2*MANT_W)'(lg_i.mant) * (2*MANT_W)'(lg_i.mant);
      sq_top = sq[2*MANT_W-1:MANT_W-1];
      lg_in  = lg_i;
      if (STEP < LOG_FRAC) begin
         if (sq_top[MANT_W]) begin
            lg_in.mant = sq_top[MANT_W:1];
            lg_in.frac = {lg_i.frac[LOG_FRAC-2:0], 1'b1};
         end else begin
            lg_in.mant = sq_top[MANT_W-1:0];
            lg_in.frac = {lg_i.frac[LOG_FRAC-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         lg_ff   <= lg_in;
         x_ff    <= x_i;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign lg_o   = lg_ff;
   assign x_o    = x_ff;

endmodule

// ===== tb/euv_band_intensity_scaler_tb.sv =====
`timescale 1ns / 1ps

module euv_band_intensity_scaler_tb;
   import ebis_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [15:0]   req_pixel_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OUT_W-1:0]     rsp_scaled_value;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // shadow of the csr registers, as the block should hold them
   logic [3:0]           band_sel_q;
   logic [INV_W-1:0]     inv_exp_q;

   logic [OUT_W-1:0]     scaled_fifo[$];
   int                   mismatches;
   bit                   send_gaps;   // sender may idle
   bit                   recv_gaps;   // receiver may stall
   bit                   hold_req;    // ask receiver for a long hold-off
   int                   hold_cnt;

   euv_band_intensity_scaler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scaled_value (rsp_scaled_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------------------------------------------------------
   // Predictor: fixed-point scaling chain, 64-bit throughout
   // ---------------------------------------------------------------

   // round-half-up of n/d in Q.16
   function automatic longint unsigned to_q16(input longint unsigned n,
                                              input longint unsigned d);
      return (n * 64'd131072 + d) / (64'd2 * d);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r    = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // log10 of x/2^16, 8 fraction bits, via squaring of a Q1.30 mantissa
   function automatic longint unsigned log10_fix(input longint unsigned x);
      int              msb;
      longint unsigned mant;
      longint unsigned frac;
      longint unsigned l2;
      if (x < 64'd65536) return 0;
      msb = 0;
      for (int i = 0; i < 64; i++) if (x[i]) msb = i;
      mant = (msb <= 30) ? (x << (30 - msb)) : (x >> (msb - 30));
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            frac = frac | 64'd1;
         end
      end
      l2 = (longint'(msb - 16) << 24) | frac;
      return (l2 * 64'd1292913986) >> (24 + 32 - 8);
   endfunction

   function automatic logic [OUT_W-1:0] scale_pixel(input logic [15:0] pix_bits,
                                                   input logic [3:0] band,
                                                   input logic [INV_W-1:0] inv);
      longint unsigned gain;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned geff;
      longint unsigned x;
      longint unsigned r;
      longint          prod;
      longint          pix;
      xf_type          xf;
      bit              use_inv;
      use_inv = 1'b1;
      case (band)
         BAND_94: begin
            gain = to_q16(499803, 100000); lo = to_q16(150, 106);
            hi = to_q16(5000, 106); xf = XF_SQRT;
         end
         BAND_131: begin
            gain = to_q16(699685, 100000); lo = to_q16(700, 149);
            hi = to_q16(120000, 149); xf = XF_LOG;
         end
         BAND_171: begin
            gain = to_q16(499803, 100000); lo = to_q16(1000, 149);
            hi = to_q16(600000, 149); xf = XF_SQRT;
         end
         BAND_193: begin
            gain = to_q16(299950, 100000); lo = to_q16(1200, 22);
            hi = to_q16(60000, 22); xf = XF_LOG;
         end
         BAND_211: begin
            gain = to_q16(499801, 100000); lo = to_q16(300, 11);
            hi = to_q16(130000, 11); xf = XF_LOG;
         end
         BAND_304: begin
            gain = to_q16(499941, 100000); lo = to_q16(5000, 1211);
            hi = to_q16(200000, 1211); xf = XF_LOG;
         end
         BAND_335: begin
            gain = to_q16(699734, 100000); lo = to_q16(350, 297);
            hi = to_q16(100000, 297); xf = XF_LOG;
         end
         BAND_1600: begin
            gain = to_q16(299911, 100000); lo = 0; hi = to_q16(200, 1); xf = XF_ID;
         end
         BAND_1700: begin
            gain = to_q16(100026, 100000); lo = 0; hi = to_q16(2500, 1); xf = XF_ID;
            use_inv = 1'b0;
         end
         BAND_4500: begin
            gain = to_q16(100026, 100000); lo = 0; hi = to_q16(26000, 1); xf = XF_ID;
         end
         default: return '0;   // unused band code
      endcase
      pix  = longint'(signed'(pix_bits));
      geff = use_inv ? ((gain * inv + 64'd32768) >> 16) : gain;
      prod = pix * longint'(geff);
      if (prod < longint'(lo))      x = lo;
      else if (prod > longint'(hi)) x = hi;
      else                          x = longint'(prod);
      case (xf)
         XF_SQRT: r = int_sqrt(x);     // 2*8-16 = 0, no pre-shift
         XF_LOG:  r = log10_fix(x);
         default: r = x >> 8;
      endcase
      return (r > 64'd8388607) ? 23'h7FFFFF : r[OUT_W-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Monitors
   // ---------------------------------------------------------------

   // expectation pushed when the word is accepted
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         scaled_fifo.push_back(scale_pixel(req_pixel_in, band_sel_q, inv_exp_q));
   end

   always @(posedge clock) begin
      logic [OUT_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scaled_fifo.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: scaled_value %0d", rsp_scaled_value);
         end else begin
            want = scaled_fifo.pop_front();
            if (want !== rsp_scaled_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("scaled_value mismatch: exp %0d got %0d",
                           want, rsp_scaled_value);
            end
         end
      end
   end

   // receiver: random stalls, plus a counted long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  = 0;
      end else begin
         if (hold_req) begin
            hold_cnt = 400;
            hold_req = 1'b0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= recv_gaps ? ($urandom_range(99) >= 23) : 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver tasks
   // ---------------------------------------------------------------

   // offer one word; valid is left high on return and dropped only by a gap or by drain()
   task automatic send_pixel(input logic [15:0] p);
      while (send_gaps && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scaled_fifo.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);   // pipe is 29 deep
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_BAND_SELECT) band_sel_q = val[3:0];
      else                        inv_exp_q  = val;
   endtask

   // small pixels in half the draws, full-range or signed wider ones otherwise
   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(3))
         0:       return 16'($urandom());
         1:       return 16'($urandom_range(4000));
         2:       return 16'($urandom_range(300));
         default: return 16'($urandom_range(40000) - 20000);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reset values (band 171, unit exposure) with field extremes
   task automatic test_reset_config();
      logic [15:0] pix_list[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                   16'h8000, 16'h5555, 16'hAAAA, 16'h0100};
      foreach (pix_list[i]) send_pixel(pix_list[i]);
   endtask

   // every band code, unused ones too, and exposure extremes incl. zero
   task automatic test_band_sweep();
      logic [INV_W-1:0] inv_list[5] = '{20'd0, 20'd1, 20'd65536, 20'hFFFFF, 20'd4096};
      for (int b = 0; b < 16; b++) begin
         write_csr(CSR_BAND_SELECT, {16'($urandom_range(65535)), 4'(b)});
         write_csr(CSR_INV_EXPOSURE, inv_list[b % 5]);
         send_pixel(16'h7FFF);
         send_pixel(16'h8000);
         send_pixel(16'($urandom_range(2000)));
         repeat (50) send_pixel(rand_pixel());
      end
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_BAND_SELECT, CSR_DAT_W'($urandom_range(11)));
         write_csr(CSR_INV_EXPOSURE, CSR_DAT_W'(($urandom_range(3) == 0) ? $urandom() :
                                                $urandom_range(200000)));
         // one phase runs with no idling on either side
         send_gaps = (ph != 3);
         recv_gaps = (ph != 3);
         repeat (50) send_pixel(rand_pixel());
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering: pipe and skid fill
   task automatic test_backpressure();
      write_csr(CSR_BAND_SELECT, CSR_DAT_W'(BAND_4500));
      write_csr(CSR_INV_EXPOSURE, 20'd70000);
      send_gaps = 1'b0;
      hold_req  = 1'b1;
      repeat (100) send_pixel(rand_pixel());
      send_gaps = 1'b1;
   endtask

   // sender pauses until the pipe is empty, then resumes
   task automatic test_pause_resume();
      repeat (20) send_pixel(rand_pixel());
      drain();
      repeat (20) send_pixel(rand_pixel());
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_pixel_in = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      mismatches   = 0;
      send_gaps    = 1'b1;
      recv_gaps    = 1'b1;
      hold_req     = 1'b0;
      band_sel_q   = 4'd2;
      inv_exp_q    = 20'd65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_band_sweep();
      test_random_phases();
      test_backpressure();
      test_pause_resume();
      drain();

      if (mismatches == 0 && scaled_fifo.size() == 0) begin
         $display("[euv_band_intensity_scaler] OK");
      end else begin
         $display("[euv_band_intensity_scaler] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[euv_band_intensity_scaler] ERROR");
      $finish;
   end

endmodule
